FILE: rtl/psbd_pkg.sv
// ----------------------------------------------------------------------------
// String body decoder package
// Shared types and character constants for the string body decoder.
// ----------------------------------------------------------------------------
package psbd_pkg;

   // Literal-mode escape phase.
   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESC,
      PH_OCT,
      PH_CR
   } psbd_phase_type;

   // Decoder state carried from one character to the next.
   typedef struct packed {
      psbd_phase_type phase;
      logic [7:0]     oct_value;
      logic [1:0]     oct_count;
      logic [3:0]     high_nibble;
      logic           nibble_pending;
      logic           nibble_bad;
   } psbd_state_type;

   // One decoded result word.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       bad_digit;
      logic       end_of_string;
   } psbd_result_type;

   localparam psbd_state_type STATE_RESET = '{
      phase:          PH_NORMAL,
      oct_value:      8'h00,
      oct_count:      2'd0,
      high_nibble:    4'h0,
      nibble_pending: 1'b0,
      nibble_bad:     1'b0
   };

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F_ESC = 8'h66;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;

   localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

endpackage

FILE: rtl/psbd_step.sv
// ----------------------------------------------------------------------------
// String body decoder step logic
// Decodes one character against the current state: next state and up to two
// result words.
// ----------------------------------------------------------------------------
module psbd_step
   import psbd_pkg::*;
(
   input  logic [7:0]      ch,
   input  logic            is_hex,
   input  logic            last,
   input  psbd_state_type  state_cur,
   output psbd_state_type  state_nxt,
   output psbd_result_type res0,
   output psbd_result_type res1,
   output logic [1:0]      res_count
);

   logic        hex_bad;
   logic [3:0]  hex_val;
   logic        is_oct_digit;
   logic [2:0]  oct_digit;

   // Emit slot A: octal value closed by a non-octal character.
   // Emit slot B: the byte of this character, or the octal flush at the end.
   logic        emit_a;
   logic [7:0]  byte_a;
   logic        emit_b;
   logic [7:0]  byte_b;
   logic        bad_b;
   logic        plain_char;
   logic [1:0]  new_count;
   logic [1:0]  total;

   psbd_state_type st;

   always_comb begin
      hex_bad = 1'b0;
      hex_val = 4'h0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         hex_val = 4'(ch - CH_ZERO);
      end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
         hex_val = 4'(ch - CH_UPPER_A + 8'd10);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
         hex_val = 4'(ch - CH_LOWER_A + 8'd10);
      end else begin
         hex_bad = 1'b1;
      end
   end

   assign is_oct_digit = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
   assign oct_digit    = ch[2:0];

   always_comb begin
      st         = state_cur;
      emit_a     = 1'b0;
      byte_a     = state_cur.oct_value;
      emit_b     = 1'b0;
      byte_b     = ch;
      bad_b      = 1'b0;
      plain_char = 1'b0;
      new_count  = state_cur.oct_count + 2'd1;

      if (is_hex) begin
         if (state_cur.nibble_pending) begin
            st.nibble_pending = 1'b0;
            emit_b = 1'b1;
            byte_b = {state_cur.high_nibble, hex_val};
            bad_b  = state_cur.nibble_bad | hex_bad;
         end else if (last) begin
            emit_b = 1'b1;
            byte_b = {hex_val, 4'h0};
            bad_b  = hex_bad;
         end else begin
            st.high_nibble    = hex_val;
            st.nibble_bad     = hex_bad;
            st.nibble_pending = 1'b1;
         end
      end else begin
         case (state_cur.phase)
            PH_ESC: begin
               st.phase = PH_NORMAL;
               if (is_oct_digit) begin
                  st.oct_value = {5'b0, oct_digit};
                  st.oct_count = 2'd1;
                  st.phase     = PH_OCT;
               end else begin
                  case (ch)
                     CH_BACKSLASH, CH_LPAREN, CH_RPAREN: begin
                        emit_b = 1'b1;
                     end
                     CH_LOWER_N: begin
                        emit_b = 1'b1;
                        byte_b = CH_LF;
                     end
                     CH_LOWER_R: begin
                        emit_b = 1'b1;
                        byte_b = CH_CR;
                     end
                     CH_LOWER_T: begin
                        emit_b = 1'b1;
                        byte_b = CH_TAB;
                     end
                     CH_LOWER_B: begin
                        emit_b = 1'b1;
                        byte_b = CH_BS;
                     end
                     CH_LOWER_F_ESC: begin
                        emit_b = 1'b1;
                        byte_b = CH_FF;
                     end
                     CH_CR: begin
                        st.phase = PH_CR;
                     end
                     default: begin
                        // Line feed continuation and unknown escapes give nothing.
                     end
                  endcase
               end
            end
            PH_OCT: begin
               if (is_oct_digit && state_cur.oct_count < OCT_MAX_DIGITS) begin
                  st.oct_value = {state_cur.oct_value[4:0], oct_digit};
                  st.oct_count = new_count;
                  if (new_count >= OCT_MAX_DIGITS) begin
                     st.phase     = PH_NORMAL;
                     st.oct_count = 2'd0;
                     emit_b       = 1'b1;
                     byte_b       = {state_cur.oct_value[4:0], oct_digit};
                  end
               end else begin
                  emit_a       = 1'b1;
                  st.oct_count = 2'd0;
                  plain_char   = 1'b1;
               end
            end
            PH_CR: begin
               st.phase = PH_NORMAL;
               if (ch != CH_LF) begin
                  plain_char = 1'b1;
               end
            end
            default: begin
               plain_char = 1'b1;
            end
         endcase

         if (plain_char) begin
            if (ch == CH_BACKSLASH) begin
               st.phase = PH_ESC;
            end else begin
               st.phase = PH_NORMAL;
               emit_b   = 1'b1;
            end
         end

         // An octal escape still open at the end is flushed as a byte.
         if (last && st.phase == PH_OCT) begin
            emit_b = 1'b1;
            byte_b = st.oct_value;
         end
      end
   end

   always_comb begin
      res0  = '{data_byte: 8'h00, byte_valid: 1'b0, bad_digit: 1'b0, end_of_string: 1'b0};
      res1  = res0;
      total = 2'd0;
      if (emit_a) begin
         res0 = '{data_byte: byte_a, byte_valid: 1'b1, bad_digit: 1'b0, end_of_string: 1'b0};
         res1 = '{data_byte: byte_b, byte_valid: 1'b1, bad_digit: bad_b, end_of_string: 1'b0};
         total = emit_b ? 2'd2 : 2'd1;
      end else if (emit_b) begin
         res0 = '{data_byte: byte_b, byte_valid: 1'b1, bad_digit: bad_b, end_of_string: 1'b0};
         total = 2'd1;
      end

      state_nxt = st;
      if (last) begin
         // A string that ends without a byte still closes with a bare marker.
         if (total == 2'd0) begin
            total = 2'd1;
         end
         if (total == 2'd2) begin
            res1.end_of_string = 1'b1;
         end else begin
            res0.end_of_string = 1'b1;
         end
         state_nxt = STATE_RESET;
      end
      res_count = total;
   end

endmodule

FILE: rtl/psbd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// String body decoder result queue
// Four-entry queue that takes up to two result words per cycle and gives one.
// ----------------------------------------------------------------------------
module psbd_rsp_fifo
   import psbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      push_count,
   input  psbd_result_type push0,
   input  psbd_result_type push1,
   input  logic            pop,
   output psbd_result_type head,
   output logic            not_empty,
   output logic            room_for_two
);

   localparam int Depth = 4;
   localparam int PtrW  = $clog2(Depth);

   psbd_result_type      entry_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]        count_ff, count_in;
   logic [PtrW-1:0]      wr_ptr_next;
   logic                 do_pop;

   assign do_pop      = pop && (count_ff != '0);
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);
   assign wr_ptr_in   = wr_ptr_ff + PtrW'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + PtrW'(do_pop);
   assign count_in    = count_ff + (PtrW+1)'(push_count) - (PtrW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push1;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= (PtrW+1)'(Depth - 2));

endmodule

FILE: rtl/pdf_string_body_decoder.sv
// ----------------------------------------------------------------------------
// String body decoder
// Decodes hex and literal bodies, one character word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Result words are registered in the result queue before they are offered on
// rsp_. Throughput: one character per cycle while results are drained one
// per cycle and the queue has room for two words; a character that yields two
// words is absorbed by the four-entry result queue. Reset is synchronous and
// active high; it clears the decoder state and empties the result queue.
module pdf_string_body_decoder
   import psbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_is_hex,
   input  logic       req_last,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_bad_digit,
   output logic       rsp_end_of_string
);

   // Decoder state: escape phase, partial octal value and held hex nibble.
   psbd_state_type  state_ff, state_in;
   psbd_state_type  state_step;
   psbd_result_type res0, res1, head;
   logic [1:0]      res_count;
   logic [1:0]      push_count;
   logic            accept;
   logic            room_for_two;

   // The step logic sees the accepted character and the current state, and
   // returns up to two result words plus the state for the next character.
   psbd_step u_step (
      .ch        (req_ch),
      .is_hex    (req_is_hex),
      .last      (req_last),
      .state_cur (state_ff),
      .state_nxt (state_step),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   // A character is taken whenever the queue has room for the worst case of
   // two words, so the input never waits on a result that is merely pending.
   assign req_ready  = room_for_two;
   assign accept     = req_valid && req_ready;
   assign push_count = accept ? res_count : 2'd0;
   assign state_in   = accept ? state_step : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result words wait here until the consumer takes them, in order.
   psbd_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (res0),
      .push1        (res1),
      .pop          (rsp_ready),
      .head         (head),
      .not_empty    (rsp_valid),
      .room_for_two (room_for_two)
   );

   assign rsp_data_byte     = head.data_byte;
   assign rsp_byte_valid    = head.byte_valid;
   assign rsp_bad_digit     = head.bad_digit;
   assign rsp_end_of_string = head.end_of_string;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// String body decoder testbench
// Streams hex and literal string bodies into the decoder, one character word
// per handshake. Every result word is checked against the bytes that a
// behavioral decoder predicts. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import psbd_pkg::*;

   // One character word as it is offered on the request channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       is_hex;
      logic       last;
   } body_char_type;

   // Tracks the decoder state, predicts the bytes that each accepted
   // character word yields and checks the result words against them.
   class string_decode_tracker;
      psbd_result_type bytes_due[$];
      psbd_result_type step_bytes[$];
      psbd_phase_type  phase;
      logic [7:0]      oct_value;
      logic [1:0]      oct_count;
      logic [3:0]      high_nibble;
      logic            nibble_pending;
      logic            nibble_bad;
      int              errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase          = PH_NORMAL;
         oct_value      = 8'h00;
         oct_count      = 2'd0;
         high_nibble    = 4'h0;
         nibble_pending = 1'b0;
         nibble_bad     = 1'b0;
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction

      function void add_byte(logic [7:0] data, logic valid, logic bad);
         psbd_result_type w;
         w.data_byte     = data;
         w.byte_valid    = valid;
         w.bad_digit     = bad;
         w.end_of_string = 1'b0;
         step_bytes.push_back(w);
      endfunction

      // Returns {invalid, nibble}. An invalid digit counts as zero.
      function logic [4:0] hex_digit(logic [7:0] ch);
         logic [7:0] v;
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            v = ch - CH_ZERO;
         end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
            v = ch - CH_UPPER_A + 8'd10;
         end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
            v = ch - CH_LOWER_A + 8'd10;
         end else begin
            return 5'b1_0000;
         end
         return {1'b0, v[3:0]};
      endfunction

      // An ordinary character: a backslash opens an escape, anything else
      // passes through.
      function void plain_char(logic [7:0] ch);
         phase = PH_NORMAL;
         if (ch == CH_BACKSLASH) begin
            phase = PH_ESC;
         end else begin
            add_byte(ch, 1'b1, 1'b0);
         end
      endfunction

      function void literal_char(logic [7:0] ch);
         case (phase)
            PH_ESC: begin
               phase = PH_NORMAL;
               if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
                  oct_value = {5'd0, ch[2:0]};
                  oct_count = 2'd1;
                  phase     = PH_OCT;
               end else begin
                  case (ch)
                     CH_BACKSLASH, CH_LPAREN, CH_RPAREN: add_byte(ch, 1'b1, 1'b0);
                     CH_LOWER_N:     add_byte(CH_LF, 1'b1, 1'b0);
                     CH_LOWER_R:     add_byte(CH_CR, 1'b1, 1'b0);
                     CH_LOWER_T:     add_byte(CH_TAB, 1'b1, 1'b0);
                     CH_LOWER_B:     add_byte(CH_BS, 1'b1, 1'b0);
                     CH_LOWER_F_ESC: add_byte(CH_FF, 1'b1, 1'b0);
                     CH_CR:          phase = PH_CR;
                     // Continuation on LF and unknown escapes give nothing.
                     default: ;
                  endcase
               end
            end
            PH_OCT: begin
               if (ch >= CH_ZERO && ch <= CH_SEVEN && oct_count < OCT_MAX_DIGITS) begin
                  // Shifting by three bits keeps the value mod 256.
                  oct_value = {oct_value[4:0], ch[2:0]};
                  oct_count = oct_count + 2'd1;
                  if (oct_count == OCT_MAX_DIGITS) begin
                     phase     = PH_NORMAL;
                     oct_count = 2'd0;
                     add_byte(oct_value, 1'b1, 1'b0);
                  end
               end else begin
                  add_byte(oct_value, 1'b1, 1'b0);
                  oct_count = 2'd0;
                  plain_char(ch);
               end
            end
            PH_CR: begin
               phase = PH_NORMAL;
               if (ch != CH_LF) begin
                  plain_char(ch);
               end
            end
            default: plain_char(ch);
         endcase
      endfunction

      // Predicts the result words of one accepted character word.
      function void decode_char(logic [7:0] ch, logic is_hex, logic last);
         logic [4:0]      digit;
         psbd_result_type w;
         step_bytes.delete();
         if (is_hex) begin
            digit = hex_digit(ch);
            if (nibble_pending) begin
               nibble_pending = 1'b0;
               add_byte({high_nibble, digit[3:0]}, 1'b1, nibble_bad | digit[4]);
            end else if (last) begin
               add_byte({digit[3:0], 4'h0}, 1'b1, digit[4]);
            end else begin
               high_nibble    = digit[3:0];
               nibble_bad     = digit[4];
               nibble_pending = 1'b1;
            end
         end else begin
            literal_char(ch);
            if (last && phase == PH_OCT) begin
               add_byte(oct_value, 1'b1, 1'b0);
            end
         end
         if (last) begin
            if (step_bytes.size() == 0) begin
               add_byte(8'h00, 1'b0, 1'b0);
            end
            w = step_bytes.pop_back();
            w.end_of_string = 1'b1;
            step_bytes.push_back(w);
            clear_state();
         end
         foreach (step_bytes[i]) begin
            bytes_due.push_back(step_bytes[i]);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 200) begin
               $display("%0t: %s mismatch, expected %02h, actual %02h",
                        $time, name, want, got);
            end
         end
      endfunction

      function void check_word(psbd_result_type got);
         psbd_result_type want;
         if (bytes_due.size() == 0) begin
            errors++;
            if (errors <= 200) begin
               $display("%0t: unexpected result word, expected none, actual %02h/%0b/%0b/%0b",
                        $time, got.data_byte, got.byte_valid, got.bad_digit,
                        got.end_of_string);
            end
            return;
         end
         want = bytes_due.pop_front();
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
         compare_field("bad_digit", 8'(want.bad_digit), 8'(got.bad_digit));
         compare_field("end_of_string", 8'(want.end_of_string), 8'(got.end_of_string));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_ch;
   logic       req_is_hex;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_bad_digit;
   logic       rsp_end_of_string;

   body_char_type        body_chars[$];
   string_decode_tracker decode_tracker;

   pdf_string_body_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_is_hex        (req_is_hex),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_bad_digit     (rsp_bad_digit),
      .rsp_end_of_string (rsp_end_of_string)
   );

   always #4 clock = ~clock;

   // Number of idle cycles before the next word. Now and then a side enters
   // a calm stretch in which it does not idle at all, so that back-to-back
   // traffic and full output pressure are also seen.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   task automatic add_char(logic [7:0] ch, logic is_hex, logic last);
      body_char_type c;
      c.ch     = ch;
      c.is_hex = is_hex;
      c.last   = last;
      body_chars.push_back(c);
   endtask

   // Appends a whole text in one mode; the final character may carry last.
   task automatic add_text(string s, logic is_hex, logic last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], is_hex, last_at_end && (i == s.len() - 1));
      end
   endtask

   // One random string body. Hex bodies are mostly valid digits; literal
   // bodies mix plain bytes with well-formed and broken escape sequences.
   // About one string in ten flips the mode from character to character.
   task automatic add_random_string();
      string         hex_digits = "0123456789abcdefABCDEF";
      string         esc_chars  = "\\()nrtbf";
      int            tokens;
      int            pick;
      logic          hex_mode;
      logic          mixed;
      logic          m;
      body_char_type c;
      hex_mode = 1'($urandom_range(0, 1));
      mixed    = ($urandom_range(0, 9) == 0);
      tokens   = $urandom_range(1, 10);
      repeat (tokens) begin
         m    = mixed ? 1'($urandom_range(0, 1)) : hex_mode;
         pick = $urandom_range(0, 9);
         if (m) begin
            if (pick < 8) begin
               add_char(hex_digits[$urandom_range(0, 21)], 1'b1, 1'b0);
            end else begin
               add_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
         end else if (pick < 5) begin
            add_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end else begin
            add_char(CH_BACKSLASH, 1'b0, 1'b0);
            case (pick)
               5: add_char(esc_chars[$urandom_range(0, 7)], 1'b0, 1'b0);
               // Octal run; digits 8 and 9 and a fourth digit end the escape.
               6: repeat ($urandom_range(1, 4)) begin
                  add_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
               end
               7: begin
                  add_char(CH_CR, 1'b0, 1'b0);
                  if ($urandom_range(0, 1) == 1) begin
                     add_char(CH_LF, 1'b0, 1'b0);
                  end
               end
               8: add_char(CH_LF, 1'b0, 1'b0);
               // Any byte after the backslash, or none at all.
               default: if ($urandom_range(0, 1) == 1) begin
                  add_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               end
            endcase
         end
      end
      c        = body_chars.pop_back();
      c.last   = 1'b1;
      body_chars.push_back(c);
   endtask

   // Offers every character word in turn. Valid stays high with the same
   // payload until the word is taken; the handshake is sampled at the edge.
   task automatic send_chars();
      int gap;
      int calm;
      calm = 0;
      foreach (body_chars[i]) begin
         gap = draw_gap(calm);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid  <= 1'b1;
         req_ch     <= body_chars[i].ch;
         req_is_hex <= body_chars[i].is_hex;
         req_last   <= body_chars[i].last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         decode_tracker.decode_char(body_chars[i].ch, body_chars[i].is_hex,
                                    body_chars[i].last);
      end
      req_valid <= 1'b0;
   endtask

   // Takes result words with random stalls and checks each one.
   task automatic drain_words();
      psbd_result_type got;
      int              stall;
      int              calm;
      calm = 0;
      forever begin
         stall = draw_gap(calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.data_byte     = rsp_data_byte;
         got.byte_valid    = rsp_byte_valid;
         got.bad_digit     = rsp_bad_digit;
         got.end_of_string = rsp_end_of_string;
         decode_tracker.check_word(got);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_ch     <= 8'h00;
      req_is_hex <= 1'b0;
      req_last   <= 1'b0;
      rsp_ready  <= 1'b0;
      decode_tracker = new();

      // Hex: mixed-case digits, an invalid digit inside a pair, and an odd
      // digit count padded with a zero low nibble at the end.
      add_text("aFZ97", 1'b1, 1'b1);
      // A lone invalid 0xFF as the whole hex body.
      add_char(8'hFF, 1'b1, 1'b1);
      // Literal: octal 400 wraps to zero, then a two-digit octal ended by a
      // plain character, which gives two bytes in one step.
      add_text("\\400", 1'b0, 1'b0);
      add_text("\\12x", 1'b0, 1'b0);
      // Line continuation on CR LF, then an unknown escape that is dropped.
      add_char(CH_BACKSLASH, 1'b0, 1'b0);
      add_char(CH_CR, 1'b0, 1'b0);
      add_char(CH_LF, 1'b0, 1'b0);
      add_text("\\q", 1'b0, 1'b0);
      // Trailing backslash on the last character: a bare end marker.
      add_text("\\", 1'b0, 1'b1);
      // A pending octal digit flushed by last.
      add_text("\\5", 1'b0, 1'b1);
      // Modes interleaved in one string: the hex nibble survives the literal
      // bytes, and the open escape is discarded at the end.
      add_char(8'h00, 1'b0, 1'b0);
      add_text("c", 1'b1, 1'b0);
      add_char(8'hFF, 1'b0, 1'b0);
      add_char(CH_BACKSLASH, 1'b0, 1'b0);
      add_text("d", 1'b1, 1'b1);

      while (body_chars.size() < 627) add_random_string();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         drain_words();
      join_none
      send_chars();

      // Let every predicted word arrive, then watch a while for extra ones.
      while (decode_tracker.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (decode_tracker.errors == 0) begin
         $display("pdf_string_body_decoder test passed");
      end else begin
         $display("pdf_string_body_decoder test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("pdf_string_body_decoder test failed");
      $finish;
   end

endmodule
